// ===== sv/cbez_pkg.sv =====
// Package for the cubic Bezier easing solver: widths, constants, state and path codes.
// No dependencies.
`timescale 1ns / 1ps
package cbez_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int NEWTON_STEPS = 8;
    localparam int BISECT_STEPS = 17;
    localparam int EPSILON_LSB  = 1;

    // internal datapath width; coefficients stay within +-2^21 at Q.16
    localparam int DW = 40;
    localparam int NCW = $clog2(NEWTON_STEPS + 1);
    localparam int BCW = $clog2(BISECT_STEPS + 1);
    localparam int DCW = $clog2(FRAC_BITS + 3);

    localparam logic signed [DW-1:0] ONE_Q = DW'(1) <<< FRAC_BITS;
    localparam logic signed [DW-1:0] EPS   = DW'(EPSILON_LSB);
    localparam logic signed [DW-1:0] LIM   = DW'(2) <<< FRAC_BITS;

    typedef logic signed [DW-1:0] word_t;

    typedef enum logic [1:0] {
        PATH_NEWTON = 2'd0,
        PATH_BISECT = 2'd1,
        PATH_CLAMP  = 2'd2,
        PATH_NONE   = 2'd3
    } path_t;

    typedef enum logic [1:0] {
        REG_X1 = 2'd0,
        REG_Y1 = 2'd1,
        REG_X2 = 2'd2,
        REG_Y2 = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_COEF,
        S_NX1, S_NX2, S_NX3, S_NERR,
        S_ND1, S_ND2, S_NDCHK, S_NDIV, S_NUPD,
        S_BSTART,
        S_BX1, S_BX2, S_BX3, S_BCHK,
        S_Y1, S_Y2, S_Y3, S_OUT
    } state_t;

    // rounded Q product, ties away from zero; operand magnitudes stay below 2^32
    function automatic word_t mulq(input word_t a, input word_t b);
        logic [DW-1:0] ma, mb;
        logic [63:0] p;
        logic [DW-1:0] r;
        begin
            ma = a[DW-1] ? DW'(-a) : a;
            mb = b[DW-1] ? DW'(-b) : b;
            p  = ma[31:0] * mb[31:0];
            p  = p + (64'(1) << (FRAC_BITS - 1));
            r  = p[FRAC_BITS +: DW];
            mulq = (a[DW-1] ^ b[DW-1]) ? word_t'(-r) : word_t'(r);
        end
    endfunction

    function automatic word_t clamp_t(input word_t t);
        begin
            if (t < 0)
                clamp_t = '0;
            else if (t > ONE_Q)
                clamp_t = ONE_Q;
            else
                clamp_t = t;
        end
    endfunction

    function automatic logic [DW-1:0] absw(input word_t v);
        begin
            absw = v[DW-1] ? DW'(-v) : DW'(v);
        end
    endfunction

endpackage

// ===== sv/cbez_if.sv =====
// Valid/ready channel interfaces for the solver.
// No dependencies.
`timescale 1ns / 1ps
interface cbez_in_if;
    logic        valid;
    logic        ready;
    logic [16:0] progress_x;
    modport source (output valid, output progress_x, input ready);
    modport sink (input valid, input progress_x, output ready);
endinterface

interface cbez_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] eased_y;
    logic [16:0]        curve_t;
    logic [1:0]         solve_path;
    modport source (output valid, output eased_y, output curve_t, output solve_path,
                    input ready);
    modport sink (input valid, input eased_y, input curve_t, input solve_path,
                  output ready);
endinterface

interface cbez_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [17:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/cbez_div.sv =====
// Restoring divider: signed num/den in Q.16, magnitude truncated and saturated to 2.0, one fraction bit per cycle.
// Depends on cbez_pkg.
`timescale 1ns / 1ps
module cbez_div
    import cbez_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t num,
    input  word_t den,
    output logic  done,
    output word_t quo
);

    logic [DW-1:0]  md_reg, md_next;
    logic [DW+1:0]  r_reg, r_next;
    logic [FRAC_BITS+1:0] q_reg, q_next;
    logic [DCW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           neg_reg, neg_next;
    logic           done_reg, done_next;
    logic [DW+1:0]  r_sh;
    logic [DW+1:0]  qmag;

    always_comb
    begin
        md_next   = md_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        r_sh      = {r_reg[DW:0], 1'b0};
        if (start)
        begin
            md_next   = absw(den);
            r_next    = (DW+2)'(absw(num));
            q_next    = '0;
            neg_next  = num[DW-1] ^ den[DW-1];
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            // integer quotient bits 1 and 0 first, then fraction bits
            if (cnt_reg == '0)
            begin
                if (r_reg >= (DW+2)'({md_reg, 1'b0}))
                begin
                    q_next    = '1;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    if (r_reg >= (DW+2)'(md_reg))
                    begin
                        r_next = r_reg - (DW+2)'(md_reg);
                        q_next = (FRAC_BITS+2)'(1) << FRAC_BITS;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            else
            begin
                if (r_sh >= (DW+2)'(md_reg))
                begin
                    r_next = r_sh - (DW+2)'(md_reg);
                    q_next = q_reg | ((FRAC_BITS+2)'(1) << (FRAC_BITS - int'(cnt_reg)));
                end
                else
                    r_next = r_sh;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCW'(FRAC_BITS))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        md_reg  <= md_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        qmag = (q_reg == '1) ? (DW+2)'(LIM) : (DW+2)'(q_reg);
        if (qmag > (DW+2)'(LIM))
            qmag = (DW+2)'(LIM);
        quo  = neg_reg ? word_t'(-qmag[DW-1:0]) : word_t'(qmag[DW-1:0]);
        done = done_reg;
    end

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
    a_quo_lim: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (absw(quo) <= LIM))
        else $error("quotient above limit");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider busy at done");
`endif

endmodule

// ===== sv/cubic_bezier_easing_solver.sv =====
// Top level: cubic Bezier easing solver on a shared multiplier under a sequencer.
// Flow: coefficient setup, up to 8 Newton steps, then up to 17 bisection steps, then Y;
// one result at a time: no new input is accepted until the result is taken.
// Run time is set by the serial divider in each Newton step and the single multiplier.
// Reset: asynchronous active low; control points return to 16384, 6554, 16384, 65536.
// Depends on cbez_pkg, cbez_if, cbez_div.
`timescale 1ns / 1ps
module cubic_bezier_easing_solver
    import cbez_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    cbez_cfg_if.sink   cfg,
    cbez_in_if.sink    in_ch,
    cbez_out_if.source out_ch
);

    state_t state_reg, state_next;
    logic [16:0] x1_reg, x2_reg;
    logic signed [17:0] y1_reg, y2_reg;
    word_t ax_reg, bx_reg, cx_reg, ay_reg, by_reg, cy_reg;
    word_t x_reg, t_reg, t0_reg, t1_reg, h_reg, e_reg;
    word_t ax_next, bx_next, cx_next, ay_next, by_next, cy_next;
    word_t x_next, t_next, t0_next, t1_next, h_next, e_next;
    logic [NCW-1:0] ni_reg, ni_next;
    logic [BCW-1:0] bi_reg, bi_next;
    path_t path_reg, path_next;
    logic signed [18:0] yo_reg, yo_next;
    logic [16:0] to_reg, to_next;
    word_t ma, mb, mp;
    logic div_start, div_done;
    word_t quo;
    word_t ux1, ux2, uy1, uy2;

    assign mp = mulq(ma, mb);

    cbez_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (e_reg),
        .den   (h_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign cfg.ready = (state_reg == S_IDLE);
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.eased_y = yo_reg;
    assign out_ch.curve_t = to_reg;
    assign out_ch.solve_path = path_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= 17'd16384;
            y1_reg <= 18'sd6554;
            x2_reg <= 17'd16384;
            y2_reg <= 18'sd65536;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_X1: x1_reg <= cfg.data[16:0];
                REG_Y1: y1_reg <= cfg.data;
                REG_X2: x2_reg <= cfg.data[16:0];
                REG_Y2: y2_reg <= cfg.data;
            endcase
        end
    end

    assign ux1 = word_t'(x1_reg);
    assign ux2 = word_t'(x2_reg);
    assign uy1 = word_t'(y1_reg);
    assign uy2 = word_t'(y2_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_ch.valid) state_next = S_COEF;
            S_COEF:   state_next = S_NX1;
            S_NX1:    state_next = S_NX2;
            S_NX2:    state_next = S_NX3;
            S_NX3:    state_next = S_NERR;
            S_NERR:
            begin
                if (absw(h_reg - x_reg) <= EPS)
                    state_next = S_Y1;
                else
                    state_next = S_ND1;
            end
            S_ND1:    state_next = S_ND2;
            S_ND2:    state_next = S_NDCHK;
            S_NDCHK:
            begin
                if (absw(h_reg) <= EPS)
                    state_next = S_BSTART;
                else
                    state_next = S_NDIV;
            end
            S_NDIV:   if (div_done) state_next = S_NUPD;
            S_NUPD:
            begin
                if (ni_reg == NCW'(NEWTON_STEPS - 1))
                    state_next = S_BSTART;
                else
                    state_next = S_NX1;
            end
            S_BSTART:
            begin
                if (x_reg > ONE_Q)
                    state_next = S_Y1;
                else
                    state_next = S_BX1;
            end
            S_BX1:    state_next = S_BX2;
            S_BX2:    state_next = S_BX3;
            S_BX3:    state_next = S_BCHK;
            S_BCHK:
            begin
                if (absw(h_reg - x_reg) <= EPS)
                    state_next = S_Y1;
                else if (bi_reg == BCW'(BISECT_STEPS - 1))
                    state_next = S_Y1;
                else if ((x_reg > h_reg) ? (t_reg >= t1_reg) : (t0_reg >= t_reg))
                    state_next = S_Y1;
                else
                    state_next = S_BX1;
            end
            S_Y1:     state_next = S_Y2;
            S_Y2:     state_next = S_Y3;
            S_Y3:     state_next = S_OUT;
            S_OUT:    if (out_ch.ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        ma = t_reg;
        mb = t_reg;
        unique case (state_reg)
            S_NX1, S_BX1: ma = ax_reg;
            S_ND1:        ma = 3 * ax_reg;
            S_Y1:         ma = ay_reg;
            default:      ma = h_reg;
        endcase
    end

    // datapath
    always_comb
    begin
        ax_next = ax_reg; bx_next = bx_reg; cx_next = cx_reg;
        ay_next = ay_reg; by_next = by_reg; cy_next = cy_reg;
        x_next = x_reg; t_next = t_reg; t0_next = t0_reg; t1_next = t1_reg;
        h_next = h_reg; e_next = e_reg;
        ni_next = ni_reg; bi_next = bi_reg; path_next = path_reg;
        yo_next = yo_reg; to_next = to_reg;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                x_next = word_t'(in_ch.progress_x);
                ni_next = '0;
                bi_next = '0;
                path_next = PATH_NONE;
            end
            S_COEF:
            begin
                cx_next = 3 * ux1;
                bx_next = 3 * (ux2 - ux1) - 3 * ux1;
                ax_next = ONE_Q - 3 * ux1 - (3 * (ux2 - ux1) - 3 * ux1);
                cy_next = 3 * uy1;
                by_next = 3 * (uy2 - uy1) - 3 * uy1;
                ay_next = ONE_Q - 3 * uy1 - (3 * (uy2 - uy1) - 3 * uy1);
                t_next = clamp_t(x_reg);
            end
            S_NX1, S_BX1: h_next = mp + bx_reg;
            S_NX2, S_BX2: h_next = mp + cx_reg;
            S_NX3, S_BX3: h_next = mp;
            S_NERR:
            begin
                e_next = h_reg - x_reg;
                if (absw(h_reg - x_reg) <= EPS)
                    path_next = PATH_NEWTON;
            end
            S_ND1:   h_next = mp + 2 * bx_reg;
            S_ND2:   h_next = mp + cx_reg;
            S_NDCHK:
            begin
                if (absw(h_reg) > EPS)
                    div_start = 1'b1;
            end
            S_NDIV:  ;
            S_NUPD:
            begin
                t_next = clamp_t(t_reg - quo);
                ni_next = ni_reg + 1'b1;
            end
            S_BSTART:
            begin
                t0_next = '0;
                t1_next = ONE_Q;
                path_next = PATH_NONE;
                if (x_reg > ONE_Q)
                begin
                    t_next = ONE_Q;
                    path_next = PATH_CLAMP;
                end
                else
                    t_next = x_reg;
            end
            S_BCHK:
            begin
                if (absw(h_reg - x_reg) <= EPS)
                    path_next = PATH_BISECT;
                else
                begin
                    bi_next = bi_reg + 1'b1;
                    if (x_reg > h_reg)
                    begin
                        t0_next = t_reg;
                        t_next = t_reg + ((t1_reg - t_reg) >>> 1);
                    end
                    else
                    begin
                        t1_next = t_reg;
                        t_next = t0_reg + ((t_reg - t0_reg) >>> 1);
                    end
                end
            end
            S_Y1:    h_next = mp + by_reg;
            S_Y2:    h_next = mp + cy_reg;
            S_Y3:
            begin
                if (mp > word_t'(262143))
                    yo_next = 19'sh3FFFF;
                else if (mp < -word_t'(262144))
                    yo_next = -19'sd262144;
                else
                    yo_next = mp[18:0];
                to_next = t_reg[16:0];
            end
            S_OUT:   ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= ax_next; bx_reg <= bx_next; cx_reg <= cx_next;
        ay_reg <= ay_next; by_reg <= by_next; cy_reg <= cy_next;
        x_reg <= x_next; t_reg <= t_next; t0_reg <= t0_next; t1_reg <= t1_next;
        h_reg <= h_next; e_reg <= e_next;
        ni_reg <= ni_next; bi_reg <= bi_next; path_reg <= path_next;
        yo_reg <= yo_next; to_reg <= to_next;
    end

`ifndef SYNTH
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (t_reg >= 0 && t_reg <= ONE_Q))
        else $error("t out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready && !cfg.ready)
        else $error("ready while busy");
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && path_reg == PATH_CLAMP) |-> (t_reg == ONE_Q))
        else $error("clamp path with t not one");
`endif

endmodule
